// ----- hw/rtl/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int MAX_WINDOW = 64;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = IDX_W + 1;
	localparam int CFG_W      = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CFG_W-1:0] cfg_t;

	typedef struct packed {
		sample_t sample;
		logic    last;
	} in_item_t;

	typedef struct packed {
		sample_t window_max;
		logic    last_res;
		logic    short_window;
	} out_item_t;

	typedef struct packed {
		logic    shift;
		logic    started;
		idx_t    wm1;
		sample_t v;
		sample_t bcast;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swm_cell.sv -----
`default_nettype none

module swm_cell (
	input  wire logic              clk,
	input  wire swm_pkg::cell_ctl_t ctl,
	input  wire swm_pkg::idx_t      idx,
	input  wire swm_pkg::sample_t   prev,
	output swm_pkg::sample_t        fmax,
	output swm_pkg::sample_t        tap
);

	swm_pkg::sample_t fmax_q;
	swm_pkg::sample_t nxt;

	always_comb begin
		priority if (idx > ctl.wm1) begin
			nxt = ctl.bcast;
		end else if (!ctl.started) begin
			nxt = ctl.v;
		end else if (prev > ctl.v) begin
			nxt = prev;
		end else begin
			nxt = ctl.v;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			fmax_q <= nxt;
		end
	end

	assign fmax = fmax_q;
	assign tap  = (({1'b0, idx} + swm_pkg::cnt_t'(1)) == {1'b0, ctl.wm1}) ? fmax_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_maximum_unit.sv -----
// Sliding window maximum over a stream of signed samples.
// Input channel in_valid/in_stall/in_item carries one sample and its last
// mark; output channel out_valid/out_stall/out_item carries the window
// maximum with last_res and short_window. An item moves on an edge where
// valid is high and stall is low.
// cfg_valid/cfg_ready/cfg_data writes window_size (0 acts as 1, values above
// 64 act as 64); cfg_ready is always high. Write it between items.
// Each sample emits once window_size samples of its sequence have arrived;
// a sample with last always emits, flagged short_window if the window never
// filled, and ends the sequence.
// The result is written into the output register when the sample is
// accepted. Throughput: one item per cycle while the output is not stalled,
// set by the update of the row of 64 cells, each holding the maximum of the
// newest candidates up to its age, plus one 64-way tap select and compare.
// Reset clears the sequence and the output valid flag and sets window_size to 1.
// While the output item is stalled, in_stall is raised and the input holds.
`default_nettype none

module sliding_window_maximum_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire swm_pkg::in_item_t   in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output swm_pkg::out_item_t       out_item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire swm_pkg::cfg_t       cfg_data
);

	swm_pkg::idx_t      wm1_q;
	logic               started_q;
	swm_pkg::cnt_t      filled_q;
	logic               out_valid_q;
	swm_pkg::out_item_t out_item_q;

	swm_pkg::cell_ctl_t ctl;
	swm_pkg::sample_t   fmax [swm_pkg::MAX_WINDOW];
	swm_pkg::sample_t   taps [swm_pkg::MAX_WINDOW];
	swm_pkg::sample_t   tap_sel;
	swm_pkg::cnt_t      filled_nxt;
	logic               accept;
	logic               emit;
	logic               short_win;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		tap_sel = '0;
		for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
			tap_sel = tap_sel | taps[i];
		end
	end

	always_comb begin
		ctl.shift   = accept;
		ctl.started = started_q;
		ctl.wm1     = wm1_q;
		ctl.v       = in_item.sample;
		priority if (wm1_q == '0 || !started_q) begin
			ctl.bcast = in_item.sample;
		end else if (tap_sel > in_item.sample) begin
			ctl.bcast = tap_sel;
		end else begin
			ctl.bcast = in_item.sample;
		end
	end

	for (genvar g = 0; g < swm_pkg::MAX_WINDOW; g++) begin : g_cell
		swm_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.idx  (swm_pkg::idx_t'(g)),
			.prev ((g == 0) ? in_item.sample : fmax[(g == 0) ? 0 : g - 1]),
			.fmax (fmax[g]),
			.tap  (taps[g])
		);
	end

	assign filled_nxt = (filled_q < swm_pkg::cnt_t'(swm_pkg::MAX_WINDOW)) ?
		filled_q + swm_pkg::cnt_t'(1) : filled_q;
	assign short_win  = filled_nxt <= {1'b0, wm1_q};
	assign emit       = !short_win || in_item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			priority if (cfg_data == '0) begin
				wm1_q <= '0;
			end else if (cfg_data > swm_pkg::cfg_t'(swm_pkg::MAX_WINDOW)) begin
				wm1_q <= swm_pkg::idx_t'(swm_pkg::MAX_WINDOW - 1);
			end else begin
				wm1_q <= swm_pkg::idx_t'(cfg_data - swm_pkg::cfg_t'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			filled_q  <= '0;
		end else if (accept) begin
			if (in_item.last) begin
				started_q <= 1'b0;
				filled_q  <= '0;
			end else begin
				started_q <= 1'b1;
				filled_q  <= filled_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_item_q.window_max   <= ctl.bcast;
			out_item_q.last_res     <= in_item.last;
			out_item_q.short_window <= in_item.last && short_win;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/swm_checker.sv -----
`default_nettype none

module swm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire swm_pkg::in_item_t  in_item,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire swm_pkg::out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.last |=> out_valid && out_item.last_res)
		else $error("last item gave no final result");

	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.short_window |-> out_item.last_res)
		else $error("short window flagged on non-final result");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output item is held");

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	swm_pkg::in_item_t  in_item   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	swm_pkg::out_item_t out_item;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	swm_pkg::cfg_t      cfg_data  = '0;

	sliding_window_maximum_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	swm_pkg::in_item_t  sample_q[$];
	swm_pkg::out_item_t maxima_due[$];
	int        snd_idle  = 19;
	int        rcv_idle  = 71;
	logic      in_took   = 1'b0;
	int        n_sent    = 0;
	int        n_taken   = 0;
	int        n_checked = 0;
	int        n_cfg     = 0;
	int        n_err     = 0;

	// window tracker state
	swm_pkg::cfg_t     win_reg   = 7'd1;
	swm_pkg::sample_t  cand_val [swm_pkg::MAX_WINDOW];
	swm_pkg::cnt_t     cand_pos [swm_pkg::MAX_WINDOW];
	swm_pkg::idx_t     cand_head = '0;
	swm_pkg::cnt_t     cand_cnt  = '0;
	swm_pkg::cnt_t     seq_pos   = '0;
	swm_pkg::cnt_t     seq_fill  = '0;

	function automatic void next_window_max(input swm_pkg::in_item_t it, output logic emit,
			output swm_pkg::out_item_t res);
		int            w;
		swm_pkg::cnt_t pos;
		swm_pkg::cnt_t age;
		swm_pkg::idx_t tail;
		logic          done;
		w = (win_reg == 0) ? 1 : ((win_reg > swm_pkg::MAX_WINDOW) ?
			swm_pkg::MAX_WINDOW : int'(win_reg));
		pos = seq_pos;
		done = 1'b0;
		while (!done) begin
			if (cand_cnt == 0) begin
				done = 1'b1;
			end else begin
				age = pos - cand_pos[cand_head];
				if (age < w) begin
					done = 1'b1;
				end else begin
					cand_head = cand_head + 1'b1;
					cand_cnt = cand_cnt - 1'b1;
				end
			end
		end
		done = 1'b0;
		while (!done) begin
			if (cand_cnt == 0) begin
				done = 1'b1;
			end else begin
				tail = swm_pkg::idx_t'(cand_head + cand_cnt - 1);
				if (cand_val[tail] <= it.sample)
					cand_cnt = cand_cnt - 1'b1;
				else
					done = 1'b1;
			end
		end
		if (cand_cnt >= swm_pkg::MAX_WINDOW) begin
			cand_head = cand_head + 1'b1;
			cand_cnt = cand_cnt - 1'b1;
		end
		tail = swm_pkg::idx_t'(cand_head + cand_cnt);
		cand_val[tail] = it.sample;
		cand_pos[tail] = pos;
		cand_cnt = cand_cnt + 1'b1;
		seq_pos = pos + 1'b1;
		if (seq_fill < swm_pkg::MAX_WINDOW)
			seq_fill = seq_fill + 1'b1;
		emit = (seq_fill >= w) || it.last;
		res.window_max = cand_val[cand_head];
		res.last_res = it.last;
		res.short_window = it.last && (seq_fill < w);
		if (it.last) begin
			cand_head = '0;
			cand_cnt = '0;
			seq_pos = '0;
			seq_fill = '0;
		end
	endfunction

	// driver: hold the item until taken, then advance or idle
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
				in_item <= sample_q[0];
				sample_q.delete(0);
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < rcv_idle);
	end

	// monitor
	always @(posedge clk) begin : mon
		swm_pkg::out_item_t want;
		logic               emit;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (maxima_due.size() == 0) begin
					$display("%0t: unexpected item: got max %0d last %0b short %0b", $time,
						out_item.window_max, out_item.last_res, out_item.short_window);
					n_err++;
				end else begin
					want = maxima_due[0];
					maxima_due.delete(0);
					n_checked++;
					if (out_item.window_max !== want.window_max ||
							out_item.last_res !== want.last_res ||
							out_item.short_window !== want.short_window) begin
						$display("%0t: mismatch, expected %0d %0b %0b, got %0d %0b %0b",
							$time, want.window_max, want.last_res, want.short_window,
							out_item.window_max, out_item.last_res, out_item.short_window);
						n_err++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				win_reg = cfg_data;
			if (in_valid && !in_stall) begin
				n_taken++;
				next_window_max(in_item, emit, want);
				if (emit)
					maxima_due.insert(maxima_due.size(), want);
			end
		end
		in_took <= arst_n && in_valid && !in_stall;
	end

	task automatic settle();
		@(negedge clk);
		while (n_taken != n_sent || maxima_due.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_window(input swm_pkg::cfg_t v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic send(input swm_pkg::sample_t s, input logic l);
		swm_pkg::in_item_t it;
		it.sample = s;
		it.last = l;
		sample_q.insert(sample_q.size(), it);
		n_sent++;
	endtask

	task automatic random_chunk();
		swm_pkg::cfg_t    w;
		int               eff;
		int               len;
		int               style;
		int               base;
		int               step;
		int               tmp;
		int               r;
		logic             open_end;
		swm_pkg::sample_t s;
		r = $urandom_range(99);
		if (r < 6)
			w = 7'd0;
		else if (r < 12)
			w = 7'd64;
		else if (r < 16)
			w = swm_pkg::cfg_t'($urandom_range(65, 127));
		else if (r < 20)
			w = 7'd1;
		else
			w = swm_pkg::cfg_t'($urandom_range(2, 12));
		set_window(w);
		eff = (w == 0) ? 1 : ((w > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : int'(w));
		len = $urandom_range(1, 3 * eff);
		if (eff == swm_pkg::MAX_WINDOW && $urandom_range(3) == 0)
			len = $urandom_range(130, 200);
		open_end = ($urandom_range(9) == 0);
		style = $urandom_range(4);
		base = $urandom;
		step = $urandom_range(1, 3);
		if ($urandom_range(1))
			step = -step;
		for (int i = 0; i < len; i++) begin
			case (style)
				0, 4: s = swm_pkg::sample_t'($urandom);
				1: begin
					tmp = $urandom_range(6);
					s = swm_pkg::sample_t'(tmp - 3);
				end
				2: s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				default: s = swm_pkg::sample_t'(base - i * step);
			endcase
			send(s, (i == len - 1) && !open_end);
		end
	endtask

	initial begin
		int target;
		int guard;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_window(7'd1);
		send(-16'sd32768, 1'b0);
		send(16'sd32767, 1'b0);
		send(16'sd0, 1'b0);
		send(-16'sd1, 1'b1);
		set_window(7'd4);
		send(16'sd5, 1'b0);
		send(16'sd5, 1'b0);
		send(16'sd5, 1'b0);
		send(-16'sd7, 1'b0);
		send(-16'sd8, 1'b0);
		send(-16'sd9, 1'b1);
		send(16'sd100, 1'b0);
		send(-16'sd100, 1'b1);
		set_window(7'd0);
		send(16'sd3, 1'b0);
		send(-16'sd3, 1'b1);
		set_window(7'd127);
		send(16'sd1, 1'b0);
		send(16'sd2, 1'b0);
		send(16'sd32767, 1'b1);
		set_window(7'd64);
		send(-16'sd32768, 1'b1);
		set_window(7'd8);
		for (int i = 1; i <= 5; i++)
			send(swm_pkg::sample_t'(i * 10), 1'b0);
		set_window(7'd3);
		send(16'sd0, 1'b0);
		send(-16'sd5, 1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			settle();
			snd_idle = (ph == 0) ? 19 : ((ph == 1) ? 71 : 0);
			rcv_idle = (ph == 0) ? 71 : ((ph == 1) ? 19 : 0);
			target = n_sent + 265;
			while (n_sent < target)
				random_chunk();
		end

		@(negedge clk);
		while (n_taken != n_sent)
			@(negedge clk);
		guard = 0;
		while (maxima_due.size() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (5) @(negedge clk);
		if (maxima_due.size() != 0) begin
			$display("%0t: %0d window maxima never arrived", $time, maxima_due.size());
			n_err++;
		end
		$display("%0d samples sent, %0d window maxima checked, %0d window size writes",
			n_taken, n_checked, n_cfg);
		$display("covered ties, extremes, short and long sequences, resized windows");
		if (n_err == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: run timed out", $time);
		$display("tb NOT OK");
		$finish;
	end

endmodule
